/* design/bsl_pkg.sv */
// Boot stream loader package: shared types, codes and reset values.
// No dependencies.
`timescale 1ns / 1ps
package bsl_pkg;

	localparam int HEADER_WORDS = 12;
	localparam logic [3:0] HDR_ENTRY_HI = 4'(HEADER_WORDS - 3);
	localparam logic [3:0] HDR_ENTRY_LO = 4'(HEADER_WORDS - 2);
	localparam logic [3:0] HDR_SIZE     = 4'(HEADER_WORDS - 1);

	localparam logic [15:0] KEY_WORD_RST     = 16'h08AA;
	localparam logic [31:0] FAIL_ADDR_RST    = 32'h003D_7820;
	localparam logic [31:0] PFAIL_ADDR_RST   = 32'h003D_7800;
	localparam logic [31:0] MODE_ADDR_RST    = 32'h0000_07FC;
	localparam logic [31:0] STATUS_ADDR_RST  = 32'h003F_6000;
	localparam logic [15:0] STATUS_WORD_RST  = 16'hAAAA;

	typedef enum logic [2:0] {
		REG_KEY_WORD     = 3'd0,
		REG_FAIL_ADDR    = 3'd1,
		REG_PFAIL_ADDR   = 3'd2,
		REG_MODE_ADDR    = 3'd3,
		REG_STATUS_ADDR  = 3'd4,
		REG_STATUS_WORD  = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		K_FRAME = 2'd0,
		K_ERASE = 2'd1,
		K_PROG  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ACT_PROGRAM = 2'd0,
		ACT_WRITE   = 2'd1,
		ACT_FINISH  = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		RC_OK        = 3'd0,
		RC_ERASE     = 3'd1,
		RC_SEQ       = 3'd2,
		RC_KEY       = 3'd3,
		RC_PROG      = 3'd4
	} reply_t;

	typedef enum logic [2:0] {
		PH_ERASE   = 3'd0,
		PH_HEADER  = 3'd1,
		PH_DEST_HI = 3'd2,
		PH_DEST_LO = 3'd3,
		PH_DATA    = 3'd4,
		PH_PROG    = 3'd5,
		PH_SIZE    = 3'd6,
		PH_HALT    = 3'd7
	} phase_t;

	typedef struct packed {
		logic [15:0] key_word;
		logic [31:0] fail_address;
		logic [31:0] program_fail_address;
		logic [31:0] mode_address;
		logic [31:0] status_address;
		logic [15:0] status_word;
	} cfg_t;

	// result request from parser to emitter; burst = success sequence of six
	typedef struct packed {
		logic        valid;
		logic        burst;
		action_t     action;
		logic [31:0] address;
		logic [15:0] data;
		reply_t      code;
	} res_req_t;

endpackage

/* design/boot_stream_loader.sv */
// Boot stream loader top level: config registers, parser and result register.
// Depends on bsl_pkg, bsl_cfg, bsl_parser, bsl_emitter.
//
// Usage: input items (kind, sequence_req, word, failed) arrive on a
// valid/ready channel; result items (action, address, data, reply_code,
// last) leave on a valid/ready channel. Configuration registers are written
// through cfg_we/cfg_index/cfg_data; the user must write them only while the
// block is idle, which the block itself does not enforce. Each item is taken
// into an input register and parsed in the next cycle; its result is then
// loaded into the output register once it is free, and taken from there.
// Throughput is one item per cycle unless the input stalls. Items that
// give no result keep flowing while the receiver stalls; an item that
// gives a result waits in the input register until the output register
// is free, which stalls the input after one buffered item. The success
// sequence is six result items from the output register. After any
// finish report the block ignores all items until reset. Reset restores
// register defaults and waits for the erase report; there is no clearing pass.
`timescale 1ns / 1ps
module boot_stream_loader import bsl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [15:0] sequence_req,
	input  logic [15:0] word,
	input  logic        failed,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  action,
	output logic [31:0] address,
	output logic [15:0] data,
	output logic [2:0]  reply_code,
	output logic        last
);

	cfg_t        cfg;
	res_req_t    req;
	logic        slot_free;
	logic [31:0] entry_address;

	bsl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bsl_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.kind          (kind),
		.sequence_req  (sequence_req),
		.word          (word),
		.failed        (failed),
		.cfg           (cfg),
		.slot_free     (slot_free),
		.req           (req),
		.entry_address (entry_address)
	);

	bsl_emitter u_emitter (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req),
		.cfg           (cfg),
		.entry_address (entry_address),
		.slot_free     (slot_free),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.action        (action),
		.address       (address),
		.data          (data),
		.reply_code    (reply_code),
		.last          (last)
	);

endmodule

/* design/bsl_cfg.sv */
// Configuration register file of the boot stream loader.
// Depends on bsl_pkg.
`timescale 1ns / 1ps
module bsl_cfg import bsl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key_word             <= KEY_WORD_RST;
			cfg_q.fail_address         <= FAIL_ADDR_RST;
			cfg_q.program_fail_address <= PFAIL_ADDR_RST;
			cfg_q.mode_address         <= MODE_ADDR_RST;
			cfg_q.status_address       <= STATUS_ADDR_RST;
			cfg_q.status_word          <= STATUS_WORD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY_WORD:    cfg_q.key_word             <= cfg_data[15:0];
				REG_FAIL_ADDR:   cfg_q.fail_address         <= cfg_data;
				REG_PFAIL_ADDR:  cfg_q.program_fail_address <= cfg_data;
				REG_MODE_ADDR:   cfg_q.mode_address         <= cfg_data;
				REG_STATUS_ADDR: cfg_q.status_address       <= cfg_data;
				REG_STATUS_WORD: cfg_q.status_word          <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* design/bsl_parser.sv */
// Input register and image parser state machine of the boot stream loader.
// Depends on bsl_pkg.
`timescale 1ns / 1ps
module bsl_parser import bsl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [15:0] sequence_req,
	input  logic [15:0] word,
	input  logic        failed,
	input  cfg_t        cfg,
	input  logic        slot_free,
	output res_req_t    req,
	output logic [31:0] entry_address
);

	logic        v_s1;
	logic [1:0]  kind_s1;
	logic [15:0] seq_s1;
	logic [15:0] word_s1;
	logic        failed_s1;

	phase_t      phase_q, phase_n;
	logic [15:0] frame_count_q, frame_count_n;
	logic [3:0]  header_index_q, header_index_n;
	logic [31:0] entry_q, entry_n;
	logic [15:0] words_left_q, words_left_n;
	logic [31:0] dest_q, dest_n;
	logic [15:0] fc_inc;
	res_req_t    r;
	logic        adv;

	assign fc_inc = frame_count_q + 16'd1;

	always_comb begin
		phase_n        = phase_q;
		frame_count_n  = frame_count_q;
		header_index_n = header_index_q;
		entry_n        = entry_q;
		words_left_n   = words_left_q;
		dest_n         = dest_q;
		r              = '0;
		r.action       = ACT_FINISH;
		r.code         = RC_OK;
		case (phase_q)
			PH_ERASE: begin
				if (kind_s1 == K_ERASE) begin
					if (failed_s1) begin
						r.valid   = 1'b1;
						r.address = cfg.fail_address;
						r.code    = RC_ERASE;
						phase_n   = PH_HALT;
					end else begin
						phase_n        = PH_HEADER;
						header_index_n = 4'd0;
					end
				end
			end
			PH_PROG: begin
				if (kind_s1 == K_PROG) begin
					if (failed_s1) begin
						r.valid   = 1'b1;
						r.address = cfg.program_fail_address;
						r.code    = RC_PROG;
						phase_n   = PH_HALT;
					end else begin
						dest_n       = dest_q + 32'd1;
						words_left_n = words_left_q - 16'd1;
						phase_n      = (words_left_q == 16'd1) ? PH_SIZE : PH_DATA;
					end
				end
			end
			PH_HALT: ;
			default: begin
				if (kind_s1 == K_FRAME) begin
					frame_count_n = fc_inc;
					if (fc_inc != seq_s1) begin
						r.valid   = 1'b1;
						r.address = cfg.fail_address;
						r.code    = RC_SEQ;
						phase_n   = PH_HALT;
					end else begin
						case (phase_q)
							PH_HEADER: begin
								if (header_index_q == 4'd0 && word_s1 != cfg.key_word) begin
									r.valid   = 1'b1;
									r.address = cfg.fail_address;
									r.code    = RC_KEY;
									phase_n   = PH_HALT;
								end else begin
									if (header_index_q == HDR_ENTRY_HI)
										entry_n = {word_s1, 16'h0000};
									if (header_index_q == HDR_ENTRY_LO)
										entry_n = {entry_q[31:16], word_s1};
									header_index_n = header_index_q + 4'd1;
									if (header_index_q >= HDR_SIZE) begin
										header_index_n = 4'd0;
										if (word_s1 == 16'd0) begin
											r.valid = 1'b1;
											r.burst = 1'b1;
											phase_n = PH_HALT;
										end else begin
											words_left_n = word_s1;
											phase_n      = PH_DEST_HI;
										end
									end
								end
							end
							PH_DEST_HI: begin
								dest_n  = {word_s1, 16'h0000};
								phase_n = PH_DEST_LO;
							end
							PH_DEST_LO: begin
								dest_n  = {dest_q[31:16], word_s1};
								phase_n = PH_DATA;
							end
							PH_DATA: begin
								r.valid   = 1'b1;
								r.action  = ACT_PROGRAM;
								r.address = dest_q;
								r.data    = word_s1;
								phase_n   = PH_PROG;
							end
							PH_SIZE: begin
								if (word_s1 == 16'd0) begin
									r.valid = 1'b1;
									r.burst = 1'b1;
									phase_n = PH_HALT;
								end else begin
									words_left_n = word_s1;
									phase_n      = PH_DEST_HI;
								end
							end
							default: ;
						endcase
					end
				end
			end
		endcase
	end

	assign adv      = v_s1 && (!r.valid || slot_free);
	assign in_ready = !v_s1 || adv;

	always_comb begin
		req       = r;
		req.valid = v_s1 && r.valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1   <= kind;
			seq_s1    <= sequence_req;
			word_s1   <= word;
			failed_s1 <= failed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_ERASE;
			frame_count_q  <= '0;
			header_index_q <= '0;
			entry_q        <= '0;
			words_left_q   <= '0;
			dest_q         <= '0;
		end else if (adv) begin
			phase_q        <= phase_n;
			frame_count_q  <= frame_count_n;
			header_index_q <= header_index_n;
			entry_q        <= entry_n;
			words_left_q   <= words_left_n;
			dest_q         <= dest_n;
		end
	end

	assign entry_address = entry_q;

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HALT |=> phase_q == PH_HALT)
		else $error("parser left halt");

	a_item_held: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv |=> v_s1 && $stable(word_s1) && $stable(seq_s1))
		else $error("stalled item lost");

	a_req_halts: assert property (@(posedge clk) disable iff (!arst_n)
		adv && r.valid && r.action == ACT_FINISH |=> phase_q == PH_HALT)
		else $error("finish without halt");

endmodule

/* design/bsl_emitter.sv */
// Result register of the boot stream loader; expands the success sequence.
// Depends on bsl_pkg.
`timescale 1ns / 1ps
module bsl_emitter import bsl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  res_req_t    req,
	input  cfg_t        cfg,
	input  logic [31:0] entry_address,
	output logic        slot_free,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  action,
	output logic [31:0] address,
	output logic [15:0] data,
	output logic [2:0]  reply_code,
	output logic        last
);

	logic        valid_q;
	logic        burst_q;
	logic [2:0]  idx_q;
	logic [2:0]  idx_n;
	action_t     action_q;
	logic [31:0] address_q;
	logic [15:0] data_q;
	reply_t      code_q;
	logic        last_q;
	logic        mid_burst;

	assign mid_burst = burst_q && idx_q != 3'd5;
	assign slot_free = !valid_q || (out_ready && !mid_burst);
	assign idx_n     = idx_q + 3'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			burst_q <= 1'b0;
			idx_q   <= '0;
		end else if (slot_free) begin
			valid_q <= req.valid;
			burst_q <= req.valid && req.burst;
			idx_q   <= '0;
		end else if (out_ready) begin
			idx_q <= idx_n;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free) begin
			if (req.burst) begin
				action_q  <= ACT_WRITE;
				address_q <= cfg.mode_address;
				data_q    <= '0;
				code_q    <= RC_OK;
				last_q    <= 1'b0;
			end else begin
				action_q  <= req.action;
				address_q <= req.address;
				data_q    <= req.data;
				code_q    <= req.code;
				last_q    <= 1'b1;
			end
		end else if (out_ready) begin
			case (idx_n)
				3'd1, 3'd2, 3'd3: begin
					action_q  <= ACT_WRITE;
					address_q <= cfg.mode_address + {29'd0, idx_n};
					data_q    <= '0;
					last_q    <= 1'b0;
				end
				3'd4: begin
					action_q  <= ACT_PROGRAM;
					address_q <= cfg.status_address;
					data_q    <= cfg.status_word;
					last_q    <= 1'b0;
				end
				default: begin
					action_q  <= ACT_FINISH;
					address_q <= entry_address;
					data_q    <= '0;
					last_q    <= 1'b1;
				end
			endcase
			code_q <= RC_OK;
		end
	end

	assign out_valid  = valid_q;
	assign action     = action_q;
	assign address    = address_q;
	assign data       = data_q;
	assign reply_code = code_q;
	assign last       = last_q;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		burst_q |-> idx_q <= 3'd5)
		else $error("burst index out of range");

	a_burst_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && burst_q |-> (last_q == (idx_q == 3'd5)))
		else $error("burst last flag wrong");

	a_burst_valid: assert property (@(posedge clk) disable iff (!arst_n)
		burst_q |-> valid_q)
		else $error("burst without valid");

endmodule
